FILE: design/uef_pkg.sv
// uef_pkg: command and status codes, result record and controller state
// type for the unique entry FIFO. No dependencies.
`timescale 1ns / 1ps

package uef_pkg;

    localparam int CMD_W   = 3;
    localparam int REC_W   = 16;   // record number port width
    localparam int VALUE_W = 16;   // result value width

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE    = 3'd0,
        CMD_DEQUEUE    = 3'd1,
        CMD_LIST       = 3'd2,
        CMD_LIST_FLUSH = 3'd3,
        CMD_FLUSH      = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        STS_ENQUEUED  = 3'd0,
        STS_DUPLICATE = 3'd1,
        STS_FULL      = 3'd2,
        STS_DEQUEUED  = 3'd3,
        STS_EMPTY     = 3'd4,
        STS_LISTED    = 3'd5,
        STS_FLUSHED   = 3'd6,
        STS_BAD_CMD   = 3'd7
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
        logic               last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_REPLY = 3'b100
    } state_t;

endpackage

FILE: design/uef_out_buf.sv
// uef_out_buf: two-entry result buffer between the controller and m_ port.
// Depends on uef_pkg (result_t).
`timescale 1ns / 1ps

module uef_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    input  uef_pkg::result_t push_data,
    output logic             push_ready,
    output logic             pop_valid,
    input  logic             pop_ready,
    output uef_pkg::result_t pop_data
);
    import uef_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/unique_entry_fifo.sv
// unique_entry_fifo: ring-buffer FIFO of record numbers that refuses duplicates.
// Depends on uef_pkg and uef_out_buf.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_cmd, s_record_number
// m_        out        m_valid / m_ready  m_value, m_status, m_last
//
// One command transaction is taken at a time. Flush, bad command and
// operations on an empty queue reply without reading the entry memory.
// Enqueue walks the held entries one memory read per cycle, dequeue reads
// the head entry, and list and list-and-flush walk all held entries, all paced
// by the single read port of the entry memory. A two-entry buffer decouples
// results from the walk; once it is full, m_ready low holds a dequeue or
// listing walk or a pending reply in place; an enqueue search walk runs on.
// Reset (aresetn, synchronous) empties the queue; entry memory is not cleared.

module unique_entry_fifo #(
    parameter int QUEUE_DEPTH = 32,
    parameter int RECORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [uef_pkg::CMD_W-1:0]    s_cmd,
    input  logic [uef_pkg::REC_W-1:0]    s_record_number,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [uef_pkg::VALUE_W-1:0]  m_value,
    output logic [2:0]                   m_status,
    output logic                         m_last
);
    import uef_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // ring index advance
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        res = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
        return res;
    endfunction

    // entry memory, one write and one registered read port
    logic [RECORD_BITS-1:0] mem [QUEUE_DEPTH];
    logic [RECORD_BITS-1:0] rd_data_reg;

    state_t                 state_reg, state_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [RECORD_BITS-1:0] rec_reg, rec_next;
    logic [RECORD_BITS-1:0] rec_in;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;      // next read address
    logic [CNT_W-1:0]       issued_reg, issued_next;  // reads issued
    logic [CNT_W-1:0]       used_reg, used_next;      // entries consumed
    logic [CNT_W-1:0]       len_reg, len_next;        // entries to walk
    logic                   dv_reg, dv_next;          // rd_data_reg holds an entry
    status_t                reply_reg, reply_next;
    logic                   clear_reg, clear_next;

    logic                   accept;
    logic                   issue;
    logic                   consume;
    logic                   mem_wr;
    logic                   is_search;
    logic                   used_last;
    logic                   push_valid;
    logic                   push_ready;
    result_t                push_data;
    result_t                out_data;
    logic [VALUE_W-1:0]     rd_value;

    // record numbers narrower or wider than the port
    if (RECORD_BITS <= REC_W) begin : g_rec_narrow
        assign rec_in = s_record_number[RECORD_BITS-1:0];
    end else begin : g_rec_wide
        assign rec_in = {{(RECORD_BITS - REC_W){1'b0}}, s_record_number};
    end

    if (RECORD_BITS >= VALUE_W) begin : g_val_wide
        assign rd_value = rd_data_reg[VALUE_W-1:0];
    end else begin : g_val_narrow
        assign rd_value = {{(VALUE_W - RECORD_BITS){1'b0}}, rd_data_reg};
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign is_search = (cmd_reg == CMD_ENQUEUE);
    assign used_last = (used_reg == len_reg - CNT_W'(1));

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        rec_next    = rec_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        slot_next   = slot_reg;
        issued_next = issued_reg;
        used_next   = used_reg;
        len_next    = len_reg;
        dv_next     = 1'b0;
        reply_next  = reply_reg;
        clear_next  = clear_reg;
        issue       = 1'b0;
        consume     = 1'b0;
        mem_wr      = 1'b0;
        push_valid  = 1'b0;
        push_data   = '{value: '0, status: STS_EMPTY, last: 1'b1};

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next    = s_cmd;
                    rec_next    = rec_in;
                    slot_next   = head_reg;
                    issued_next = '0;
                    used_next   = '0;
                    len_next    = count_reg;
                    clear_next  = 1'b0;
                    state_next  = ST_REPLY;
                    unique case (s_cmd)
                        CMD_ENQUEUE: begin
                            if (count_reg == '0) begin
                                reply_next = STS_ENQUEUED;
                            end else begin
                                state_next = ST_WALK;
                            end
                        end
                        CMD_DEQUEUE, CMD_LIST, CMD_LIST_FLUSH: begin
                            if (s_cmd == CMD_DEQUEUE) begin
                                len_next = CNT_W'(1);
                            end
                            if (count_reg == '0) begin
                                reply_next = STS_EMPTY;
                                clear_next = (s_cmd == CMD_LIST_FLUSH);
                            end else begin
                                state_next = ST_WALK;
                            end
                        end
                        CMD_FLUSH: begin
                            reply_next = (count_reg != '0) ? STS_FLUSHED : STS_EMPTY;
                            clear_next = 1'b1;
                        end
                        default: begin
                            reply_next = STS_BAD_CMD;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                if (is_search && dv_reg && (rd_data_reg == rec_reg)) begin
                    // duplicate: abandon the walk
                    reply_next = STS_DUPLICATE;
                    clear_next = 1'b0;
                    state_next = ST_REPLY;
                end else begin
                    consume = dv_reg && (is_search || push_ready);
                    issue   = (issued_reg != len_reg) && (!dv_reg || consume);
                    dv_next = issue ? 1'b1 : (consume ? 1'b0 : dv_reg);
                    if (issue) begin
                        slot_next   = wrap_inc(slot_reg);
                        issued_next = issued_reg + CNT_W'(1);
                    end
                    if (!is_search) begin
                        push_valid       = dv_reg;
                        push_data.value  = rd_value;
                        push_data.status = (cmd_reg == CMD_DEQUEUE) ? STS_DEQUEUED
                                                                    : STS_LISTED;
                        push_data.last   = (cmd_reg == CMD_DEQUEUE) ||
                                           ((cmd_reg == CMD_LIST) && used_last);
                    end
                    if (consume) begin
                        used_next = used_reg + CNT_W'(1);
                        if (used_last) begin
                            dv_next = 1'b0;
                            case (cmd_reg)
                                CMD_ENQUEUE: begin
                                    reply_next = (count_reg >= CNT_W'(QUEUE_DEPTH))
                                               ? STS_FULL : STS_ENQUEUED;
                                    clear_next = 1'b0;
                                    state_next = ST_REPLY;
                                end
                                CMD_DEQUEUE: begin
                                    head_next  = wrap_inc(head_reg);
                                    count_next = count_reg - CNT_W'(1);
                                    state_next = ST_IDLE;
                                end
                                CMD_LIST_FLUSH: begin
                                    reply_next = STS_FLUSHED;
                                    clear_next = 1'b1;
                                    state_next = ST_REPLY;
                                end
                                default: begin
                                    state_next = ST_IDLE;
                                end
                            endcase
                        end
                    end
                end
            end

            ST_REPLY: begin
                push_valid       = 1'b1;
                push_data.status = reply_reg;
                if (push_ready) begin
                    state_next = ST_IDLE;
                    if (reply_reg == STS_ENQUEUED) begin
                        // memory write lands before any later walk reads it
                        mem_wr     = 1'b1;
                        tail_next  = wrap_inc(tail_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (clear_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            dv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            dv_reg    <= dv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        rec_reg    <= rec_next;
        slot_reg   <= slot_next;
        issued_reg <= issued_next;
        used_reg   <= used_next;
        len_reg    <= len_next;
        reply_reg  <= reply_next;
        clear_reg  <= clear_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem[tail_reg] <= rec_reg;
        end
        if (issue) begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    uef_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (m_valid),
        .pop_ready  (m_ready),
        .pop_data   (out_data)
    );

    assign m_value  = out_data.value;
    assign m_status = out_data.status;
    assign m_last   = out_data.last;

    // occupancy never exceeds the ring
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // head meets tail only when the ring is empty or full
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == tail_reg) == ((count_reg == '0) || (count_reg == CNT_W'(QUEUE_DEPTH))))
        else $error("head/tail inconsistent with entry count");

    // read data is only pending during a walk
    a_dv_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg |-> (state_reg == ST_WALK))
        else $error("read data pending outside walk");

    // a walk that returns to idle hands its final result to the buffer
    a_dequeue_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) && (state_next == ST_IDLE) |-> push_valid && push_ready)
        else $error("walk ended without delivering its result");

endmodule
